### rtl/core/mss_pkg.sv
// Package with the shared types and constants of the merge sort block.
package mss_pkg;

    localparam int MAX_ELEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int COUNT_W    = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam int STK_DEPTH  = ADDR_W + 2;
    localparam int STK_IW     = $clog2(STK_DEPTH);
    localparam int STK_CW     = $clog2(STK_DEPTH + 1);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] data_value;
        logic                         is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         last_out;
        logic [COUNT_W-1:0]           compare_count;
        logic [COUNT_W-1:0]           move_count;
        logic                         overflow;
    } t_out_item;

    // Progress of one range on the recursion stack.
    typedef enum logic [1:0] {
        PH_LEFT  = 2'd0,
        PH_RIGHT = 2'd1,
        PH_MERGE = 2'd2
    } t_phase;

endpackage

### rtl/core/mss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/merge_sort_with_counts_top.sv
// Top level of the merge sort block: load, top-down merge sort and emit.
//
// The block stores one request per cycle until the request marked last, then
// sorts the stored values ascending by a stable top-down merge sort (left half
// the larger one, ties keep the left element) and returns every value in order
// with the comparison and write counts of the merges. Sorting runs a recursion
// stack in registers over one element store and one scratch memory, both with
// a registered read port: each merge copies its range into the scratch memory
// and then merges it back into the store. Each result is read from the store,
// captured and held until it is taken. Requests beyond 64 stored values are
// dropped and flagged in every result of that set. The input is stalled from
// the last request until the final result has been taken.
module merge_sort_with_counts_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mss_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output mss_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import mss_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_STACK = 12'b000000000010,
        ST_C_RD  = 12'b000000000100,
        ST_C_WR  = 12'b000000001000,
        ST_M_RA  = 12'b000000010000,
        ST_M_RB  = 12'b000000100000,
        ST_M_WB  = 12'b000001000000,
        ST_M_CMP = 12'b000010000000,
        ST_M_WT  = 12'b000100000000,
        ST_E_RD  = 12'b001000000000,
        ST_E_CAP = 12'b010000000000,
        ST_E_WT  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_fill;
    logic [COUNT_W-1:0] r_cmp, r_mov;
    logic               r_drop;

    logic [ADDR_W-1:0]  r_stk_lo [STK_DEPTH];
    logic [ADDR_W-1:0]  r_stk_hi [STK_DEPTH];
    t_phase             r_stk_ph [STK_DEPTH];
    logic [STK_CW-1:0]  r_sp;

    logic [ADDR_W-1:0]  r_lo, r_mid, r_hi, r_c, r_e;
    logic [CNT_W-1:0]   r_p, r_q, r_k;
    logic signed [DATA_WIDTH-1:0] r_a, r_b;
    logic               r_sel;
    t_out_item          r_out;

    // Memory ports.
    logic                  st_we, sc_we;
    logic [ADDR_W-1:0]     st_waddr, st_raddr, sc_waddr, sc_raddr;
    logic [DATA_WIDTH-1:0] st_wdata, st_rdata, sc_wdata, sc_rdata;

    // Decoded view of the stack top and the merge pointers.
    logic [STK_IW-1:0]  tp;
    logic [ADDR_W-1:0]  t_lo, t_hi, t_mid;
    t_phase             t_ph;
    logic               lp, lq, take_left;
    logic               in_acc, full;
    logic [CNT_W-1:0]   fill_inc;

    assign tp    = STK_IW'(r_sp - STK_CW'(1));
    assign t_lo  = r_stk_lo[tp];
    assign t_hi  = r_stk_hi[tp];
    assign t_ph  = r_stk_ph[tp];
    assign t_mid = t_lo + ((t_hi - t_lo) >> 1);

    assign lp        = r_p <= {1'b0, r_mid};
    assign lq        = r_q <= {1'b0, r_hi};
    assign take_left = lp && (!lq || (r_a <= r_b));

    assign in_acc   = (r_state == ST_IDLE) && i_in_valid;
    assign full     = r_fill == CNT_W'(MAX_ELEMS);
    assign fill_inc = r_fill + CNT_W'(1);

    mss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    mss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    // Store writes come from loading or from merging; reads from copy or emit.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_fill[ADDR_W-1:0];
        st_wdata = i_in_data.data_value;
        st_raddr = (r_state == ST_C_RD) ? r_c : r_e;
        sc_we    = r_state == ST_C_WR;
        sc_waddr = r_c;
        sc_wdata = st_rdata;
        sc_raddr = r_p[ADDR_W-1:0];
        if (in_acc && !full) begin
            st_we = 1'b1;
        end
        if (r_state == ST_M_CMP) begin
            st_we    = lp || lq;
            st_waddr = r_k[ADDR_W-1:0];
            st_wdata = take_left ? r_a : r_b;
            sc_raddr = take_left ? ADDR_W'(r_p + CNT_W'(1)) : ADDR_W'(r_q + CNT_W'(1));
        end else if (r_state == ST_M_RB) begin
            sc_raddr = r_q[ADDR_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid && i_in_data.is_last) n_state = ST_STACK;
            ST_STACK: begin
                if (r_sp == '0) begin
                    n_state = ST_E_RD;
                end else if (t_lo < t_hi && t_ph == PH_MERGE) begin
                    n_state = ST_C_RD;
                end
            end
            ST_C_RD:  n_state = ST_C_WR;
            ST_C_WR:  n_state = (r_c == r_hi) ? ST_M_RA : ST_C_RD;
            ST_M_RA:  n_state = ST_M_RB;
            ST_M_RB:  n_state = ST_M_WB;
            ST_M_WB:  n_state = ST_M_CMP;
            ST_M_CMP: n_state = (lp || lq) ? ST_M_WT : ST_STACK;
            ST_M_WT:  n_state = ST_M_CMP;
            ST_E_RD:  n_state = ST_E_CAP;
            ST_E_CAP: n_state = ST_E_WT;
            ST_E_WT: begin
                if (!i_out_stall) begin
                    n_state = r_out.last_out ? ST_IDLE : ST_E_RD;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_cmp   <= '0;
            r_mov   <= '0;
            r_drop  <= 1'b0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_fill <= fill_inc;
                        end
                        if (i_in_data.is_last) begin
                            r_sp <= STK_CW'(1);
                        end
                    end
                end
                ST_STACK: begin
                    if (r_sp != '0) begin
                        if (t_lo >= t_hi || t_ph == PH_MERGE) begin
                            r_sp <= r_sp - STK_CW'(1);
                        end else begin
                            r_sp <= r_sp + STK_CW'(1);
                        end
                    end
                end
                ST_M_CMP: begin
                    if (lp && lq && r_cmp != COUNT_MAX) begin
                        r_cmp <= r_cmp + COUNT_W'(1);
                    end
                    if ((lp || lq) && r_mov != COUNT_MAX) begin
                        r_mov <= r_mov + COUNT_W'(1);
                    end
                end
                ST_E_WT: begin
                    if (!i_out_stall && r_out.last_out) begin
                        r_fill <= '0;
                        r_cmp  <= '0;
                        r_mov  <= '0;
                        r_drop <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Stack entries, merge pointers and the output register.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_stk_lo[0] <= '0;
                r_stk_hi[0] <= full ? ADDR_W'(MAX_ELEMS - 1) : r_fill[ADDR_W-1:0];
                r_stk_ph[0] <= PH_LEFT;
            end
            ST_STACK: begin
                if (r_sp != '0 && t_lo < t_hi) begin
                    case (t_ph)
                        PH_LEFT: begin
                            r_stk_ph[tp] <= PH_RIGHT;
                            r_stk_lo[STK_IW'(r_sp)] <= t_lo;
                            r_stk_hi[STK_IW'(r_sp)] <= t_mid;
                            r_stk_ph[STK_IW'(r_sp)] <= PH_LEFT;
                        end
                        PH_RIGHT: begin
                            r_stk_ph[tp] <= PH_MERGE;
                            r_stk_lo[STK_IW'(r_sp)] <= t_mid + ADDR_W'(1);
                            r_stk_hi[STK_IW'(r_sp)] <= t_hi;
                            r_stk_ph[STK_IW'(r_sp)] <= PH_LEFT;
                        end
                        default: begin
                            r_lo  <= t_lo;
                            r_mid <= t_mid;
                            r_hi  <= t_hi;
                            r_c   <= t_lo;
                        end
                    endcase
                end
                r_e <= '0;
            end
            ST_C_WR: begin
                r_c <= r_c + ADDR_W'(1);
                r_p <= {1'b0, r_lo};
                r_q <= {1'b0, r_mid} + CNT_W'(1);
                r_k <= {1'b0, r_lo};
            end
            ST_M_RB:  r_a <= sc_rdata;
            ST_M_WB:  r_b <= sc_rdata;
            ST_M_CMP: begin
                r_k   <= r_k + CNT_W'(1);
                r_sel <= !take_left;
                if (take_left) begin
                    r_p <= r_p + CNT_W'(1);
                end else begin
                    r_q <= r_q + CNT_W'(1);
                end
            end
            ST_M_WT: begin
                if (r_sel) begin
                    r_b <= sc_rdata;
                end else begin
                    r_a <= sc_rdata;
                end
            end
            ST_E_CAP: begin
                r_out.sorted_value  <= st_rdata;
                r_out.last_out      <= ({1'b0, r_e} + CNT_W'(1)) == r_fill;
                r_out.compare_count <= r_cmp;
                r_out.move_count    <= r_mov;
                r_out.overflow      <= r_drop;
            end
            ST_E_WT: begin
                if (!i_out_stall) begin
                    r_e <= r_e + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_state == ST_E_WT;
    assign o_out_data  = r_out;

endmodule
